[hw/rtl/csa_pkg.sv]
// Shared constants, types and helpers for the cosine similarity accumulator.
// No dependencies; used by csa_mul, csa_seq and the top level.
`timescale 1ns / 1ps

package csa_pkg;

  localparam int MAX_LEN    = 1024;
  localparam int ELEM_WIDTH = 16;

  localparam int FIELD_W = 16;
  localparam int SIM_W   = 16;
  localparam int ACC_W   = 48;
  localparam int CHUNK_W = ACC_W / 2;
  localparam int MUL_W   = ((ELEM_WIDTH > CHUNK_W) ? ELEM_WIDTH : CHUNK_W) + 1;
  localparam int MPROD_W = 2 * MUL_W;
  localparam int PROD_W  = 2 * ACC_W;
  localparam int Q_FRAC  = 15;
  localparam int Q_W     = Q_FRAC + 1;
  localparam int Q_LIMIT = 2 ** Q_FRAC;
  localparam int K_W     = $clog2(Q_W);
  localparam int T_W     = PROD_W + Q_W;
  localparam int SRCH_W  = PROD_W + 2 * Q_W;
  localparam int PP_W    = 3;
  localparam int CNT_W   = $clog2(MAX_LEN + 1);

  localparam logic [MUL_W-1:0] ELEM_MASK =
    {{(MUL_W - ELEM_WIDTH){1'b0}}, {ELEM_WIDTH{1'b1}}};

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_AB,
    ST_AA,
    ST_BB,
    ST_NB,
    ST_MAG,
    ST_PP_MUL,
    ST_PP_ADD,
    ST_SQ_X,
    ST_SQ_Y,
    ST_SQ_UPD,
    ST_RES
  } state_e;

  typedef struct packed {
    logic             valid;
    logic [SIM_W-1:0] similarity;
    logic             zero_norm;
    logic             length_overflow;
  } res_t;

  // low ELEM_WIDTH bits of the field, sign-extended from bit ELEM_WIDTH-1
  function automatic logic [MUL_W-1:0] sext_elem(logic [FIELD_W-1:0] f);
    logic [MUL_W-1:0] v;
    v = MUL_W'(f) & ELEM_MASK;
    if (v[ELEM_WIDTH-1]) begin
      v = v | ~ELEM_MASK;
    end
    return v;
  endfunction

endpackage

[hw/rtl/csa_mul.sv]
// Registered signed multiplier shared by accumulation and the partial products for the final search.
// Depends on csa_pkg for operand widths.
`timescale 1ns / 1ps

module csa_mul (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic signed [csa_pkg::MUL_W-1:0]   a_i,
  input  logic signed [csa_pkg::MUL_W-1:0]   b_i,
  output logic signed [csa_pkg::MPROD_W-1:0] prod_o
);

  logic signed [csa_pkg::MPROD_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= a_i * b_i;
    end
  end

  assign prod_o = prod_q;

endmodule

[hw/rtl/csa_seq.sv]
// Sequencer and datapath: accumulates dot and norms, then builds the Q1.15
// magnitude bit by bit with one shared adder. Depends on csa_pkg, csa_mul.
`timescale 1ns / 1ps

module csa_seq (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [csa_pkg::FIELD_W-1:0] elem_a_i,
  input  logic [csa_pkg::FIELD_W-1:0] elem_b_i,
  input  logic                        last_i,
  input  logic                        out_free_i,
  output csa_pkg::res_t               res_o
);

  csa_pkg::state_e state_q, state_d;

  logic [csa_pkg::MUL_W-1:0]  a_q, a_d, b_q, b_d;
  logic                       last_q, last_d;
  logic [csa_pkg::ACC_W-1:0]  dot_q, dot_d, na_q, na_d, nb_q, nb_d;
  logic [csa_pkg::CNT_W-1:0]  cnt_q, cnt_d;
  logic                       ovf_q, ovf_d;
  logic                       neg_q, neg_d, zn_q, zn_d;
  logic [csa_pkg::ACC_W-1:0]  mag_q, mag_d;
  logic [csa_pkg::PROD_W-1:0] p_q, p_d, r_q, r_d;
  logic [csa_pkg::SRCH_W-1:0] s_q, s_d, w_q, w_d;
  logic [csa_pkg::T_W-1:0]    t_q, t_d;
  logic [csa_pkg::Q_W-1:0]    q_q, q_d;
  logic [csa_pkg::K_W-1:0]    k_q, k_d;
  logic [csa_pkg::PP_W-1:0]   pp_q, pp_d;

  logic                               mul_en;
  logic signed [csa_pkg::MUL_W-1:0]   mul_a, mul_b;
  logic signed [csa_pkg::MPROD_W-1:0] mul_p;
  logic [csa_pkg::ACC_W-1:0]          prod;

  logic [csa_pkg::SRCH_W-1:0]  add_a, add_b, add_s;
  logic [csa_pkg::ACC_W-1:0]   pp_x, pp_y;
  logic [csa_pkg::CHUNK_W-1:0] pp_xc, pp_yc;
  logic [6:0]                  pp_shift;
  logic                        fit;
  logic [csa_pkg::Q_W-1:0]     qc;
  logic [csa_pkg::SIM_W-1:0]   sim;

  csa_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (mul_p)
  );

  assign prod  = mul_p[csa_pkg::ACC_W-1:0];
  assign add_s = add_a + add_b;

  always_comb begin
    pp_x  = pp_q[2] ? mag_q : na_q;
    pp_y  = pp_q[2] ? mag_q : nb_q;
    pp_xc = pp_q[0] ? pp_x[csa_pkg::ACC_W-1:csa_pkg::CHUNK_W] : pp_x[csa_pkg::CHUNK_W-1:0];
    pp_yc = pp_q[1] ? pp_y[csa_pkg::ACC_W-1:csa_pkg::CHUNK_W] : pp_y[csa_pkg::CHUNK_W-1:0];
    case (pp_q[1:0])
      2'b00:   pp_shift = 7'd0;
      2'b11:   pp_shift = 7'(2 * csa_pkg::CHUNK_W);
      default: pp_shift = 7'(csa_pkg::CHUNK_W);
    endcase
    fit = w_q <= (csa_pkg::SRCH_W'(r_q) << (2 * csa_pkg::Q_FRAC));
    qc  = (q_q > csa_pkg::Q_W'(csa_pkg::Q_LIMIT)) ? csa_pkg::Q_W'(csa_pkg::Q_LIMIT) : q_q;
    if (neg_q) begin
      sim = csa_pkg::SIM_W'(csa_pkg::Q_W'(0) - qc);
    end else if (qc > csa_pkg::Q_W'(csa_pkg::Q_LIMIT - 1)) begin
      sim = csa_pkg::SIM_W'(csa_pkg::Q_LIMIT - 1);
    end else begin
      sim = csa_pkg::SIM_W'(qc);
    end
  end

  always_comb begin
    state_d = state_q;
    a_d = a_q;  b_d = b_q;  last_d = last_q;
    dot_d = dot_q;  na_d = na_q;  nb_d = nb_q;
    cnt_d = cnt_q;  ovf_d = ovf_q;
    neg_d = neg_q;  zn_d = zn_q;  mag_d = mag_q;
    p_d = p_q;  r_d = r_q;  s_d = s_q;  t_d = t_q;  w_d = w_q;
    q_d = q_q;  k_d = k_q;  pp_d = pp_q;
    mul_en = 1'b0;
    mul_a  = a_q;
    mul_b  = b_q;
    add_a  = '0;
    add_b  = '0;
    in_ready_o = 1'b0;
    res_o = '0;

    unique case (state_q)
      csa_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          a_d    = csa_pkg::sext_elem(elem_a_i);
          b_d    = csa_pkg::sext_elem(elem_b_i);
          last_d = last_i;
          if (cnt_q < csa_pkg::CNT_W'(csa_pkg::MAX_LEN)) begin
            state_d = csa_pkg::ST_AB;
          end else begin
            ovf_d   = 1'b1;
            state_d = last_i ? csa_pkg::ST_MAG : csa_pkg::ST_IDLE;
          end
        end
      end
      csa_pkg::ST_AB: begin
        mul_en  = 1'b1;
        state_d = csa_pkg::ST_AA;
      end
      csa_pkg::ST_AA: begin
        mul_en  = 1'b1;
        mul_b   = a_q;
        add_a   = csa_pkg::SRCH_W'(dot_q);
        add_b   = csa_pkg::SRCH_W'(prod);
        dot_d   = add_s[csa_pkg::ACC_W-1:0];
        state_d = csa_pkg::ST_BB;
      end
      csa_pkg::ST_BB: begin
        mul_en  = 1'b1;
        mul_a   = b_q;
        add_a   = csa_pkg::SRCH_W'(na_q);
        add_b   = csa_pkg::SRCH_W'(prod);
        na_d    = add_s[csa_pkg::ACC_W-1:0];
        state_d = csa_pkg::ST_NB;
      end
      csa_pkg::ST_NB: begin
        add_a   = csa_pkg::SRCH_W'(nb_q);
        add_b   = csa_pkg::SRCH_W'(prod);
        nb_d    = add_s[csa_pkg::ACC_W-1:0];
        cnt_d   = cnt_q + 1'b1;
        state_d = last_q ? csa_pkg::ST_MAG : csa_pkg::ST_IDLE;
      end
      csa_pkg::ST_MAG: begin
        // magnitude of dot via the adder: ~x + 1 when negative
        add_a = csa_pkg::SRCH_W'(dot_q[csa_pkg::ACC_W-1] ? ~dot_q : dot_q);
        add_b = csa_pkg::SRCH_W'(dot_q[csa_pkg::ACC_W-1]);
        mag_d = add_s[csa_pkg::ACC_W-1:0];
        p_d   = '0;
        r_d   = '0;
        s_d   = '0;
        t_d   = '0;
        q_d   = '0;
        pp_d  = '0;
        k_d   = csa_pkg::K_W'(csa_pkg::Q_W - 1);
        if (na_q == '0 || nb_q == '0) begin
          zn_d    = 1'b1;
          neg_d   = 1'b0;
          state_d = csa_pkg::ST_RES;
        end else begin
          zn_d    = 1'b0;
          neg_d   = dot_q[csa_pkg::ACC_W-1];
          state_d = csa_pkg::ST_PP_MUL;
        end
      end
      csa_pkg::ST_PP_MUL: begin
        mul_en  = 1'b1;
        mul_a   = csa_pkg::MUL_W'(pp_xc);
        mul_b   = csa_pkg::MUL_W'(pp_yc);
        state_d = csa_pkg::ST_PP_ADD;
      end
      csa_pkg::ST_PP_ADD: begin
        add_a = csa_pkg::SRCH_W'(pp_q[2] ? r_q : p_q);
        add_b = csa_pkg::SRCH_W'(prod) << pp_shift;
        if (pp_q[2]) begin
          r_d = add_s[csa_pkg::PROD_W-1:0];
        end else begin
          p_d = add_s[csa_pkg::PROD_W-1:0];
        end
        pp_d    = pp_q + 1'b1;
        state_d = (pp_q == '1) ? csa_pkg::ST_SQ_X : csa_pkg::ST_PP_MUL;
      end
      csa_pkg::ST_SQ_X: begin
        // candidate c = q + 2^k: c^2 P = S + (qP << k+1) + (P << 2k)
        add_a   = s_q;
        add_b   = csa_pkg::SRCH_W'(t_q) << ({1'b0, k_q} + 1'b1);
        w_d     = add_s;
        state_d = csa_pkg::ST_SQ_Y;
      end
      csa_pkg::ST_SQ_Y: begin
        add_a   = w_q;
        add_b   = csa_pkg::SRCH_W'(p_q) << {k_q, 1'b0};
        w_d     = add_s;
        state_d = csa_pkg::ST_SQ_UPD;
      end
      csa_pkg::ST_SQ_UPD: begin
        add_a = csa_pkg::SRCH_W'(t_q);
        add_b = csa_pkg::SRCH_W'(p_q) << k_q;
        if (fit) begin
          s_d = w_q;
          t_d = add_s[csa_pkg::T_W-1:0];
          q_d = q_q | (csa_pkg::Q_W'(1) << k_q);
        end
        k_d     = k_q - 1'b1;
        state_d = (k_q == '0) ? csa_pkg::ST_RES : csa_pkg::ST_SQ_X;
      end
      csa_pkg::ST_RES: begin
        if (out_free_i) begin
          res_o.valid           = 1'b1;
          res_o.similarity      = zn_q ? '0 : sim;
          res_o.zero_norm       = zn_q;
          res_o.length_overflow = ovf_q;
          dot_d   = '0;
          na_d    = '0;
          nb_d    = '0;
          cnt_d   = '0;
          ovf_d   = 1'b0;
          state_d = csa_pkg::ST_IDLE;
        end
      end
      default: state_d = csa_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= csa_pkg::ST_IDLE;
      dot_q   <= '0;
      na_q    <= '0;
      nb_q    <= '0;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      dot_q   <= dot_d;
      na_q    <= na_d;
      nb_q    <= nb_d;
      cnt_q   <= cnt_d;
      ovf_q   <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    b_q    <= b_d;
    last_q <= last_d;
    neg_q  <= neg_d;
    zn_q   <= zn_d;
    mag_q  <= mag_d;
    p_q    <= p_d;
    r_q    <= r_d;
    s_q    <= s_d;
    t_q    <= t_d;
    w_q    <= w_d;
    q_q    <= q_d;
    k_q    <= k_d;
    pp_q   <= pp_d;
  end

  a_res_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> out_free_i)
    else $error("result issued while output slot busy");

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |=> (dot_q == '0 && na_q == '0 && nb_q == '0 && cnt_q == '0 && !ovf_q))
    else $error("accumulators not cleared after result");

  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= csa_pkg::CNT_W'(csa_pkg::MAX_LEN))
    else $error("pair count beyond limit");

  a_zero_sim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.zero_norm) |-> res_o.similarity == '0)
    else $error("zero norm with nonzero similarity");

endmodule

[hw/rtl/cosine_similarity_accumulator_unit.sv]
// Top level of the cosine similarity accumulator: stream ports and result register.
// Depends on csa_pkg and csa_seq.
`timescale 1ns / 1ps
//
// Input channel s_axis: one item is one pair of signed elements (a, b);
// s_axis_tlast marks the final pair of the two vectors. Each item is taken in
// the idle state and then passes through the shared multiplier and adder in
// the states AB, AA, BB and NB before the next pair is taken. The final pair
// goes on to the dot magnitude, the two 48x48 products built from four
// 24x24 partial products each, and the 16 result bits (three adder passes a
// bit), and then hands the result over. tready is low meanwhile.
// A pair beyond the length limit is dropped in its accept cycle, and a final
// pair with a zero norm skips the products and the search.
// Output channel m_axis: one item per vector pair, carrying the Q1.15 result
// and the zero-norm and length-overflow flags. The result waits in an output
// register; the block keeps accepting pairs while it waits, and a later
// final pair holds its result until the register is free.
// Reset clears the accumulators, pair count and overflow flag, and empties
// the output register.

module cosine_similarity_accumulator_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [15:0] elem_a, [31:16] elem_b
  input  logic        s_axis_tlast,   // last_pair
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] similarity
  output logic [1:0]  m_axis_tuser    // [0] zero_norm, [1] length_overflow
);

  csa_pkg::res_t res;
  logic          out_free;
  logic          m_valid_q;
  logic [15:0]   m_data_q;
  logic [1:0]    m_user_q;

  assign out_free = !m_valid_q || m_axis_tready;

  csa_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .elem_a_i   (s_axis_tdata[15:0]),
    .elem_b_i   (s_axis_tdata[31:16]),
    .last_i     (s_axis_tlast),
    .out_free_i (out_free),
    .res_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (res.valid) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      m_data_q <= res.similarity;
      m_user_q <= {res.length_overflow, res.zero_norm};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

endmodule

[verif/tb.sv]
// Self-checking bench for cosine_similarity_accumulator_unit: streams element pairs,
// predicts each Q1.15 similarity and its flags, and checks every output item in order.
// Depends on csa_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb;

  localparam int HOLD_CYCLES  = 800;
  localparam int SETTLE_CYCLES = 100;

  typedef enum int {KIND_FULL, KIND_SMALL, KIND_EXTREME, KIND_ZERO} elem_kind_e;
  typedef enum int {LINK_FREE, LINK_SAME, LINK_NEG, LINK_NEAR} link_e;

  typedef struct {
    logic signed [15:0] sim;
    logic               zero_norm;
    logic               len_ovf;
  } score_t;

  class similarity_board;
    logic signed [csa_pkg::ACC_W-1:0] dot_sum;
    logic [csa_pkg::ACC_W-1:0]        norm_a_sum;
    logic [csa_pkg::ACC_W-1:0]        norm_b_sum;
    int unsigned                      pair_cnt;
    logic                             overflow_flag;
    score_t                           expected_scores[$];
    int                               failures;

    function new();
      clear_sums();
      failures = 0;
    endfunction

    function void clear_sums();
      dot_sum       = '0;
      norm_a_sum    = '0;
      norm_b_sum    = '0;
      pair_cnt      = 0;
      overflow_flag = 1'b0;
    endfunction

    // largest q in [0, 2^15] with q^2 * na * nb <= 2^30 * mag^2
    function logic [16:0] cos_quotient(logic [47:0] mag, logic [47:0] na, logic [47:0] nb);
      logic [127:0] norm_prod;
      logic [127:0] bound;
      logic [127:0] trial;
      logic [16:0]  lo;
      logic [16:0]  hi;
      logic [16:0]  mid;
      norm_prod = 128'(na) * 128'(nb);
      bound     = (128'(mag) * 128'(mag)) << 30;
      lo = '0;
      hi = 17'd32768;
      while (lo < hi) begin
        mid   = 17'((32'(lo) + 32'(hi) + 1) >> 1);
        trial = norm_prod * 128'(mid) * 128'(mid);
        if (trial <= bound) begin
          lo = mid;
        end else begin
          hi = mid - 17'd1;
        end
      end
      return lo;
    endfunction

    function void note_pair(logic [15:0] a_bits, logic [15:0] b_bits, logic last);
      logic signed [csa_pkg::ACC_W-1:0] a;
      logic signed [csa_pkg::ACC_W-1:0] b;
      logic [csa_pkg::ACC_W-1:0]        mag;
      logic [16:0]                      q;
      score_t                           s;
      a = $signed(a_bits[csa_pkg::ELEM_WIDTH-1:0]);
      b = $signed(b_bits[csa_pkg::ELEM_WIDTH-1:0]);
      if (pair_cnt < csa_pkg::MAX_LEN) begin
        dot_sum    = dot_sum + a * b;
        norm_a_sum = norm_a_sum + a * a;
        norm_b_sum = norm_b_sum + b * b;
        pair_cnt++;
      end else begin
        overflow_flag = 1'b1;
      end
      if (!last) begin
        return;
      end
      s.len_ovf = overflow_flag;
      if (norm_a_sum == '0 || norm_b_sum == '0) begin
        s.zero_norm = 1'b1;
        s.sim       = '0;
      end else begin
        s.zero_norm = 1'b0;
        mag = dot_sum[csa_pkg::ACC_W-1] ? -dot_sum : dot_sum;
        q   = cos_quotient(mag, norm_a_sum, norm_b_sum);
        if (dot_sum[csa_pkg::ACC_W-1]) begin
          s.sim = ~q[15:0] + 16'd1;
        end else begin
          s.sim = (q > 17'd32767) ? 16'sh7fff : q[15:0];
        end
      end
      expected_scores = {expected_scores, s};
      clear_sums();
    endfunction

    function void check_score(logic signed [15:0] sim, logic zero_norm, logic len_ovf);
      score_t s;
      if (expected_scores.size() == 0) begin
        $error("unexpected result item: similarity %0d", sim);
        failures++;
        return;
      end
      s = expected_scores.pop_front();
      if (sim !== s.sim) begin
        $error("similarity: expected %0d, got %0d", s.sim, sim);
        failures++;
      end
      if (zero_norm !== s.zero_norm) begin
        $error("zero_norm: expected %0b, got %0b", s.zero_norm, zero_norm);
        failures++;
      end
      if (len_ovf !== s.len_ovf) begin
        $error("length_overflow: expected %0b, got %0b", s.len_ovf, len_ovf);
        failures++;
      end
    endfunction
  endclass

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  similarity_board scores  = new();
  int unsigned     send_idle_pct = 0;
  int unsigned     stall_pct     = 0;
  logic            hold_go       = 1'b0;
  logic            holding       = 1'b0;

  cosine_similarity_accumulator_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // result side: check on handshake, then pick next ready
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        scores.check_score($signed(m_axis_tdata), m_axis_tuser[0], m_axis_tuser[1]);
      end
      m_axis_tready <= !holding && ($urandom_range(99) >= stall_pct);
    end
  end

  // long receiver hold-off, counted here
  initial begin : rx_hold
    wait (hold_go);
    @(posedge clk_i);
    holding <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    holding <= 1'b0;
  end

  initial begin : watchdog
    #10_000_000;
    $display("tb NOT OK");
    $finish;
  end

  function automatic elem_kind_e pick_kind();
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) return KIND_ZERO;
    if (r < 3) return KIND_EXTREME;
    if (r < 6) return KIND_SMALL;
    return KIND_FULL;
  endfunction

  function automatic logic [15:0] pick_elem(elem_kind_e kind);
    case (kind)
      KIND_ZERO: begin
        return 16'h0000;
      end
      KIND_SMALL: begin
        return 16'($urandom_range(128)) - 16'd64;
      end
      KIND_EXTREME: begin
        case ($urandom_range(4))
          0: return 16'h7fff;
          1: return 16'h8000;
          2: return 16'h0001;
          3: return 16'hffff;
          default: return 16'h8001;
        endcase
      end
      default: begin
        return 16'($urandom);
      end
    endcase
  endfunction

  task automatic send_pair(input logic [15:0] a_bits, input logic [15:0] b_bits,
                           input logic last);
    if (send_idle_pct != 0) begin
      while ($urandom_range(99) < send_idle_pct) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {b_bits, a_bits};
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    scores.note_pair(a_bits, b_bits, last);
  endtask

  // sender pauses until every pending result is out
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (scores.expected_scores.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_vector(input int len);
    elem_kind_e  a_kind;
    elem_kind_e  b_kind;
    link_e       link;
    logic [15:0] a;
    logic [15:0] b;
    a_kind = pick_kind();
    b_kind = pick_kind();
    link   = link_e'($urandom_range(3));
    for (int i = 0; i < len; i++) begin
      a = pick_elem(a_kind);
      case (link)
        LINK_SAME: b = a;
        LINK_NEG:  b = -a;
        LINK_NEAR: b = a + pick_elem(KIND_SMALL);
        default:   b = pick_elem(b_kind);
      endcase
      send_pair(a, b, i == len - 1);
    end
  endtask

  task automatic run_random(input int n_pairs);
    int sent;
    int len;
    sent = 0;
    while (sent < n_pairs) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
      send_vector(len);
      sent += len;
      if ($urandom_range(19) == 0) begin
        drain();
      end
    end
  endtask

  initial begin : stimulus
    int unsigned idle_by_phase[4];
    int unsigned stall_by_phase[4];
    idle_by_phase  = '{0, 80, 0, 30};
    stall_by_phase = '{0, 0, 80, 30};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // full-scale equal and opposite vectors hit both saturation limits
    send_pair(16'h7fff, 16'h7fff, 1'b1);
    send_pair(16'h8000, 16'h8000, 1'b1);
    send_pair(16'h7fff, 16'h8001, 1'b1);
    send_pair(16'h8000, 16'h7fff, 1'b1);
    send_pair(16'hffff, 16'h0001, 1'b1);
    send_pair(16'h0001, 16'h8000, 1'b1);
    // zero norms
    send_pair(16'h0000, 16'h04d2, 1'b1);
    send_pair(16'h04d2, 16'h0000, 1'b1);
    send_pair(16'h0000, 16'h0000, 1'b1);
    send_pair(16'h0000, 16'h0007, 1'b0);
    send_pair(16'h0000, 16'hfff7, 1'b1);
    // orthogonal, then a mixed three-pair vector
    send_pair(16'h0001, 16'h0000, 1'b0);
    send_pair(16'h0000, 16'h0001, 1'b1);
    send_pair(16'h0003, 16'h0004, 1'b0);
    send_pair(16'h0004, 16'hfffd, 1'b0);
    send_pair(16'hfffb, 16'h0005, 1'b1);
    drain();

    for (int p = 0; p < 4; p++) begin
      send_idle_pct = idle_by_phase[p];
      stall_pct    <= stall_by_phase[p];
      run_random(40);
      drain();
    end

    // a vector running past MAX_LEN
    send_idle_pct = 0;
    stall_pct    <= 0;
    send_vector(csa_pkg::MAX_LEN + 1 + $urandom_range(3));
    drain();

    // receiver holds off while short vectors keep coming
    hold_go <= 1'b1;
    for (int v = 0; v < 20; v++) begin
      send_vector($urandom_range(4, 1));
    end
    drain();

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (scores.failures == 0 && scores.expected_scores.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/csa_pkg.sv
hw/rtl/csa_mul.sv
hw/rtl/csa_seq.sv
hw/rtl/cosine_similarity_accumulator_unit.sv
verif/tb.sv
